// ----- design/slfd_pkg.sv -----
// Shared types, constants and a helper function for the sidelink slot finder.
package slfd_pkg;

    // Field widths fixed by the register map and the item format
    localparam int SLOT_W  = 64;
    localparam int NUM_W   = 3;
    localparam int T1_W    = 8;
    localparam int T2_W    = 11;
    localparam int LEN_W   = 8;
    localparam int BASE_W  = 7;
    localparam int T2MIN_W = BASE_W + (1 << NUM_W);
    localparam int OFF_W   = T2_W + 1;
    localparam int CNT_W   = $clog2(SLOT_W);
    localparam int BMP_W   = 64;
    localparam int BMP_BITS = 3 * BMP_W;

    // Stream payload layout
    localparam int IN_DATA_W = ((SLOT_W + NUM_W + T1_W + T2_W + 7) / 8) * 8;

    // Configuration port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_BMP0     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BMP1     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BMP2     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_POOL_LEN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_T2MIN    = 3'd4;

    localparam logic [LEN_W-1:0]  POOL_LEN_RST = 8'd10;
    localparam logic [BASE_W-1:0] T2MIN_RST    = 7'd1;

    // Defaults for the top-level parameters
    localparam int MAX_POOL_LEN_DEF = 192;
    localparam int MASK_BITS_DEF    = 64;
    localparam int MAX_WINDOW_DEF   = 2048;

    // Result limits and walk width
    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS);
    localparam int LANES       = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        JOB_OK,
        JOB_ERR,
        JOB_EMPTY
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [T1_W-1:0]   t1;
        logic [T2_W-1:0]   t2;
        logic [LEN_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
    } job_t;

    // One restoring-division step: shift in a dividend bit, subtract if it fits.
    function automatic logic [LEN_W-1:0] mod_step(
        input logic [LEN_W-1:0] rem,
        input logic             din,
        input logic [LEN_W-1:0] len
    );
        logic [LEN_W:0] tmp;
        tmp = {rem, din};
        if (tmp >= {1'b0, len})
        begin
            tmp = tmp - {1'b0, len};
        end
        return tmp[LEN_W-1:0];
    endfunction

endpackage

// ----- design/sidelink_candidate_slot_finder_unit.sv -----
// Top level of the sidelink candidate slot finder: config registers and stream ports.
//
// Each request on the input stream carries a current absolute slot, a numerology and
// a selection window [t1, t2]. The block checks t2min = t2min_base << numerology
// against t2; if t2min is larger it returns one error result (tuser = 1, last).
// Otherwise it walks window slots over the periodic sidelink pool bitmap and returns
// one MASK_BITS-slot candidate mask per chunk, each tagged with its slot offset, at most
// 32 results, the final one with tlast; an empty window (t1 > t2) gives one empty
// last result. The front end computes the pool start position with a
// restoring divider that takes one bit of current_slot per cycle; a normal
// request then waits in the push state until the job queue has room (error and
// empty requests skip the divider and go from idle straight to the push state).
// The back end walks up to 8 bitmap positions per cycle while it builds a chunk,
// then loads the mask into the output register and holds it until it is taken.
// A two-entry job queue sits between the front and back ends, so the next request's
// modulo runs while the current window is still being emitted. Configuration goes
// through the APB port (64-bit data, register i at byte address 8*i) and may be
// written only while the block is idle. No clearing pass is needed after reset.
module sidelink_candidate_slot_finder_unit #(
    parameter int MAX_POOL_LEN = slfd_pkg::MAX_POOL_LEN_DEF,
    parameter int MASK_BITS    = slfd_pkg::MASK_BITS_DEF,
    parameter int MAX_WINDOW   = slfd_pkg::MAX_WINDOW_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: current_slot[63:0], numerology[66:64], window_start[74:67],
    //        window_end[85:75], zero pad
    input  logic [slfd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: chunk_offset[10:0], candidate_mask[MASK_BITS+10:11], zero pad
    output logic [((slfd_pkg::T2_W + MASK_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // tuser: status
    output logic [0:0]                         m_axis_tuser,
    output logic                               m_axis_tlast,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [slfd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [slfd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [slfd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int OUT_DATA_W = ((slfd_pkg::T2_W + MASK_BITS + 7) / 8) * 8;
    localparam int PAD_W      = OUT_DATA_W - slfd_pkg::T2_W - MASK_BITS;

    // Configuration registers
    logic [slfd_pkg::BMP_W-1:0]  bmp0_reg;
    logic [slfd_pkg::BMP_W-1:0]  bmp1_reg;
    logic [slfd_pkg::BMP_W-1:0]  bmp2_reg;
    logic [slfd_pkg::LEN_W-1:0]  pool_len_reg;
    logic [slfd_pkg::BASE_W-1:0] t2min_base_reg;

    logic [slfd_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_write;

    // Queue hookup
    logic            q_push;
    slfd_pkg::job_t  q_push_job;
    logic            q_full;
    logic            q_pop;
    slfd_pkg::job_t  q_pop_job;
    logic            q_empty;

    // Result register contents
    logic                       res_status;
    logic [slfd_pkg::T2_W-1:0]  res_offset;
    logic [MASK_BITS-1:0]       res_mask;

    // Decode on the 8-byte register slot; low address bits are don't-care.
    assign reg_idx   = paddr[slfd_pkg::APB_ADDR_W-1:slfd_pkg::APB_ADDR_W-slfd_pkg::REG_IDX_W];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bmp0_reg       <= '0;
            bmp1_reg       <= '0;
            bmp2_reg       <= '0;
            pool_len_reg   <= slfd_pkg::POOL_LEN_RST;
            t2min_base_reg <= slfd_pkg::T2MIN_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                slfd_pkg::REG_BMP0:     bmp0_reg       <= pwdata;
                slfd_pkg::REG_BMP1:     bmp1_reg       <= pwdata;
                slfd_pkg::REG_BMP2:     bmp2_reg       <= pwdata;
                slfd_pkg::REG_POOL_LEN: pool_len_reg   <= pwdata[slfd_pkg::LEN_W-1:0];
                slfd_pkg::REG_T2MIN:    t2min_base_reg <= pwdata[slfd_pkg::BASE_W-1:0];
                default:                ;
            endcase
        end
    end

    // Read back the addressed register, zero for unused slots.
    always_comb
    begin
        case (reg_idx)
            slfd_pkg::REG_BMP0:     prdata = bmp0_reg;
            slfd_pkg::REG_BMP1:     prdata = bmp1_reg;
            slfd_pkg::REG_BMP2:     prdata = bmp2_reg;
            slfd_pkg::REG_POOL_LEN: prdata = slfd_pkg::APB_DATA_W'(pool_len_reg);
            slfd_pkg::REG_T2MIN:    prdata = slfd_pkg::APB_DATA_W'(t2min_base_reg);
            default:                prdata = '0;
        endcase
    end

    // Front end: classify the request and find its starting pool position.
    slfd_front #(
        .MAX_POOL_LEN (MAX_POOL_LEN),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_data     (s_axis_tdata),
        .pool_length (pool_len_reg),
        .t2min_base  (t2min_base_reg),
        .push        (q_push),
        .push_job    (q_push_job),
        .full        (q_full)
    );

    // Job queue: lets the next modulo run while the walker still emits.
    slfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_pop_job),
        .empty    (q_empty)
    );

    // Back end: walk the bitmap chunk by chunk and drive the result register.
    slfd_back #(
        .MASK_BITS (MASK_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .bitmap     ({bmp2_reg, bmp1_reg, bmp0_reg}),
        .q_empty    (q_empty),
        .q_job      (q_pop_job),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (res_status),
        .out_offset (res_offset),
        .out_mask   (res_mask),
        .out_last   (m_axis_tlast)
    );

    // Pack the result transaction: offset in the low bits, then the mask.
    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[slfd_pkg::T2_W-1:0] = res_offset;
        m_axis_tdata[slfd_pkg::T2_W +: MASK_BITS] = res_mask;
    end

    assign m_axis_tuser = res_status;

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata >> (slfd_pkg::T2_W + MASK_BITS)) == '0)
        else $error("result padding not zero");

    a_cfg_len: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && reg_idx == slfd_pkg::REG_POOL_LEN) |=>
        pool_len_reg == $past(pwdata[slfd_pkg::LEN_W-1:0]))
        else $error("pool length write lost");

    a_pad_width: assert property (@(posedge clk) disable iff (!rst_n)
        PAD_W >= 0 && PAD_W < 8)
        else $error("result packing width wrong");

endmodule

// ----- design/slfd_queue.sv -----
// Short job queue between the request front end and the chunk walker.
module slfd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  slfd_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output slfd_pkg::job_t pop_job,
    output logic          empty
);

    localparam int PTR_W = $clog2(slfd_pkg::QUEUE_DEPTH);
    localparam int FILL_W = $clog2(slfd_pkg::QUEUE_DEPTH + 1);

    slfd_pkg::job_t     store_reg [slfd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (fill_reg == FILL_W'(slfd_pkg::QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(slfd_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(slfd_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> (fill_reg == FILL_W'(slfd_pkg::QUEUE_DEPTH)) || $past(do_pop))
        else $error("queue fill dropped without a pop");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(slfd_pkg::QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !push) |=> empty)
        else $error("queue left empty without a push");

endmodule

// ----- design/slfd_front.sv -----
// Request front end: window checks and serial pool-position modulo.
module slfd_front #(
    parameter int MAX_POOL_LEN = slfd_pkg::MAX_POOL_LEN_DEF,
    parameter int MAX_WINDOW   = slfd_pkg::MAX_WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [slfd_pkg::IN_DATA_W-1:0]    in_data,
    input  logic [slfd_pkg::LEN_W-1:0]        pool_length,
    input  logic [slfd_pkg::BASE_W-1:0]       t2min_base,
    output logic                              push,
    output slfd_pkg::job_t                    push_job,
    input  logic                              full
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PUSH
    } state_t;

    localparam int SLOT_W = slfd_pkg::SLOT_W;
    localparam int LEN_W  = slfd_pkg::LEN_W;
    localparam int T1_W   = slfd_pkg::T1_W;
    localparam int T2_W   = slfd_pkg::T2_W;
    localparam int NUM_W  = slfd_pkg::NUM_W;

    state_t                     state_reg;
    logic [slfd_pkg::CNT_W-1:0] cnt_reg;
    logic [SLOT_W-1:0]          cur_reg;
    logic [T1_W-1:0]            t1_shift_reg;
    logic [LEN_W-1:0]           rem_a_reg;
    logic [LEN_W-1:0]           rem_b_reg;
    slfd_pkg::job_t             job_reg;

    logic [SLOT_W-1:0]          in_cur;
    logic [NUM_W-1:0]           in_num;
    logic [T1_W-1:0]            in_t1;
    logic [T2_W-1:0]            in_t2;
    logic [slfd_pkg::T2MIN_W-1:0] t2min;
    logic [T2_W-1:0]            t2_sat;
    logic [LEN_W-1:0]           len_sat;
    logic                       accept;
    logic [LEN_W-1:0]           rem_a_next;
    logic [LEN_W:0]             pos_sum;
    logic [LEN_W-1:0]           pos_final;

    assign in_cur = in_data[SLOT_W-1:0];
    assign in_num = in_data[SLOT_W +: NUM_W];
    assign in_t1  = in_data[SLOT_W + NUM_W +: T1_W];
    assign in_t2  = in_data[SLOT_W + NUM_W + T1_W +: T2_W];

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign push     = (state_reg == ST_PUSH);
    assign push_job = job_reg;

    always_comb
    begin
        t2min = slfd_pkg::T2MIN_W'(t2min_base) << in_num;
        t2_sat = (in_t2 > T2_W'(MAX_WINDOW - 1)) ? T2_W'(MAX_WINDOW - 1) : in_t2;
        if (pool_length == '0)
        begin
            len_sat = LEN_W'(1);
        end
        else if (pool_length > LEN_W'(MAX_POOL_LEN))
        begin
            len_sat = LEN_W'(MAX_POOL_LEN);
        end
        else
        begin
            len_sat = pool_length;
        end
    end

    // Step the slot remainder; on the final step, fold the two partial remainders together.
    always_comb
    begin
        rem_a_next = slfd_pkg::mod_step(rem_a_reg, cur_reg[SLOT_W-1], job_reg.len);
        pos_sum    = {1'b0, rem_a_next} + {1'b0, rem_b_reg};
        pos_final  = (pos_sum >= {1'b0, job_reg.len}) ?
                     LEN_W'(pos_sum - {1'b0, job_reg.len}) : pos_sum[LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        job_reg.t1   <= in_t1;
                        job_reg.t2   <= t2_sat;
                        job_reg.len  <= len_sat;
                        job_reg.pos  <= '0;
                        cur_reg      <= in_cur;
                        t1_shift_reg <= in_t1;
                        rem_a_reg    <= '0;
                        rem_b_reg    <= '0;
                        cnt_reg      <= '0;
                        if (t2min > slfd_pkg::T2MIN_W'(in_t2))
                        begin
                            job_reg.kind <= slfd_pkg::JOB_ERR;
                            state_reg    <= ST_PUSH;
                        end
                        else if (T2_W'(in_t1) > t2_sat)
                        begin
                            job_reg.kind <= slfd_pkg::JOB_EMPTY;
                            state_reg    <= ST_PUSH;
                        end
                        else
                        begin
                            job_reg.kind <= slfd_pkg::JOB_OK;
                            state_reg    <= ST_DIVIDE;
                        end
                    end
                end
                ST_DIVIDE:
                begin
                    rem_a_reg <= rem_a_next;
                    cur_reg   <= cur_reg << 1;
                    if (cnt_reg < slfd_pkg::CNT_W'(T1_W))
                    begin
                        rem_b_reg    <= slfd_pkg::mod_step(rem_b_reg, t1_shift_reg[T1_W-1],
                                                           job_reg.len);
                        t1_shift_reg <= t1_shift_reg << 1;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == slfd_pkg::CNT_W'(SLOT_W - 1))
                    begin
                        job_reg.pos <= pos_final;
                        state_reg   <= ST_PUSH;
                    end
                end
                ST_PUSH:
                begin
                    if (!full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (rem_a_reg < job_reg.len) && (rem_b_reg < job_reg.len))
        else $error("partial remainder not below pool length");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (push && job_reg.kind == slfd_pkg::JOB_OK) |-> (job_reg.pos < job_reg.len))
        else $error("pool position out of range");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> !in_ready)
        else $error("ready raised during modulo");

endmodule

// ----- design/slfd_back.sv -----
// Chunk walker: steps the pool bitmap and builds one candidate mask per chunk.
module slfd_back #(
    parameter int MASK_BITS = slfd_pkg::MASK_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [slfd_pkg::BMP_BITS-1:0] bitmap,
    input  logic                          q_empty,
    input  slfd_pkg::job_t                q_job,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_status,
    output logic [slfd_pkg::T2_W-1:0]     out_offset,
    output logic [MASK_BITS-1:0]          out_mask,
    output logic                          out_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_HOLD
    } state_t;

    localparam int OFF_W  = slfd_pkg::OFF_W;
    localparam int LEN_W  = slfd_pkg::LEN_W;
    localparam int LANES  = slfd_pkg::LANES;
    localparam int BIDX_W = (MASK_BITS > 1) ? $clog2(MASK_BITS) : 1;

    state_t                         state_reg;
    logic [slfd_pkg::T2_W-1:0]      t2_reg;
    logic [LEN_W-1:0]               len_reg;
    logic [OFF_W-1:0]               off_reg;
    logic [LEN_W-1:0]               pos_reg;
    logic [BIDX_W-1:0]              bidx_reg;
    logic [MASK_BITS-1:0]           mask_reg;
    logic [slfd_pkg::RES_CNT_W-1:0] n_reg;
    logic                           out_valid_reg;
    logic                           out_status_reg;
    logic [slfd_pkg::T2_W-1:0]      out_offset_reg;
    logic [MASK_BITS-1:0]           out_mask_reg;
    logic                           out_last_reg;

    logic [LANES-1:0]               lane_bits;
    logic [LEN_W-1:0]               pos_after;
    logic [MASK_BITS-1:0]           mask_after;
    logic                           chunk_done;
    logic                           final_chunk;

    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_offset = out_offset_reg;
    assign out_mask   = out_mask_reg;
    assign out_last   = out_last_reg;

    // Walk up to LANES pool positions; lanes past the chunk or window end hold pos.
    always_comb
    begin
        logic [OFF_W-1:0] idx;
        logic [LEN_W-1:0] p;
        logic [LEN_W:0]   p_inc;
        logic [OFF_W-1:0] next_idx;
        p = pos_reg;
        lane_bits = '0;
        p_inc = '0;
        for (int j = 0; j < LANES; j++)
        begin
            idx = OFF_W'(bidx_reg) + OFF_W'(j);
            if ((idx < OFF_W'(MASK_BITS)) && (off_reg + idx <= OFF_W'(t2_reg)))
            begin
                lane_bits[j] = bitmap[p];
                p_inc = {1'b0, p} + 1'b1;
                p = (p_inc >= {1'b0, len_reg}) ? '0 : p_inc[LEN_W-1:0];
            end
        end
        pos_after  = p;
        mask_after = mask_reg | (MASK_BITS'(lane_bits) << bidx_reg);
        next_idx   = OFF_W'(bidx_reg) + OFF_W'(LANES);
        chunk_done = (next_idx >= OFF_W'(MASK_BITS)) ||
                     (off_reg + next_idx > OFF_W'(t2_reg));
        final_chunk = (n_reg == slfd_pkg::RES_CNT_W'(slfd_pkg::MAX_RESULTS - 1)) ||
                      (off_reg + OFF_W'(MASK_BITS) > OFF_W'(t2_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        case (q_job.kind)
                            slfd_pkg::JOB_OK:
                            begin
                                t2_reg    <= q_job.t2;
                                len_reg   <= q_job.len;
                                off_reg   <= OFF_W'(q_job.t1);
                                pos_reg   <= q_job.pos;
                                bidx_reg  <= '0;
                                mask_reg  <= '0;
                                n_reg     <= '0;
                                state_reg <= ST_BUILD;
                            end
                            slfd_pkg::JOB_EMPTY:
                            begin
                                out_status_reg <= 1'b0;
                                out_offset_reg <= slfd_pkg::T2_W'(q_job.t1);
                                out_mask_reg   <= '0;
                                out_last_reg   <= 1'b1;
                                out_valid_reg  <= 1'b1;
                                state_reg      <= ST_HOLD;
                            end
                            default:
                            begin
                                out_status_reg <= 1'b1;
                                out_offset_reg <= '0;
                                out_mask_reg   <= '0;
                                out_last_reg   <= 1'b1;
                                out_valid_reg  <= 1'b1;
                                state_reg      <= ST_HOLD;
                            end
                        endcase
                    end
                end
                ST_BUILD:
                begin
                    mask_reg <= mask_after;
                    pos_reg  <= pos_after;
                    bidx_reg <= bidx_reg + BIDX_W'(LANES);
                    if (chunk_done)
                    begin
                        out_status_reg <= 1'b0;
                        out_offset_reg <= off_reg[slfd_pkg::T2_W-1:0];
                        out_mask_reg   <= mask_after;
                        out_last_reg   <= final_chunk;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            off_reg   <= off_reg + OFF_W'(MASK_BITS);
                            n_reg     <= n_reg + 1'b1;
                            bidx_reg  <= '0;
                            mask_reg  <= '0;
                            state_reg <= ST_BUILD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg) |-> (out_last_reg && out_mask_reg == '0))
        else $error("error result not a single empty last result");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUILD) |-> (pos_reg < len_reg))
        else $error("pool position out of range in walk");

    a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && n_reg == slfd_pkg::RES_CNT_W'(slfd_pkg::MAX_RESULTS - 1) &&
         state_reg == ST_HOLD && !out_status_reg) |-> out_last_reg)
        else $error("result count cap missed");

    a_valid_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_HOLD))
        else $error("output valid outside hold");

endmodule
